/* design/ipv4fe_pkg.sv */
package ipv4fe_pkg;

  localparam int unsigned ROUTE_ENTRIES_DEF = 64;
  localparam int unsigned MAC_ENTRIES_DEF   = 64;
  localparam int unsigned PORT_COUNT_DEF    = 16;

  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned CNT_CMP_W  = 11;
  localparam int unsigned PORT_CMP_W = 9;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned CSUM_WORDS = 9;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

  localparam logic [1:0] OP_ROUTE = 2'd0;
  localparam logic [1:0] OP_MAC   = 2'd1;
  localparam logic [1:0] OP_FWD   = 2'd2;

  localparam logic [2:0] V_FORWARD   = 3'd0;
  localparam logic [2:0] V_NOT_IPV4  = 3'd1;
  localparam logic [2:0] V_BAD_CSUM  = 3'd2;
  localparam logic [2:0] V_NO_ROUTE  = 3'd3;
  localparam logic [2:0] V_TTL_ZERO  = 3'd4;
  localparam logic [2:0] V_NO_MAC    = 3'd5;
  localparam logic [2:0] V_LOAD_DONE = 3'd6;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  entry_index;
    logic [31:0] entry_ip;
    logic [31:0] entry_mask;
    logic [31:0] entry_next_hop;
    logic [3:0]  entry_port;
    logic [47:0] entry_mac;
    logic [15:0] frame_type;
    logic [63:0] hdr_first;
    logic [63:0] hdr_middle;
    logic [31:0] hdr_dest;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [3:0]  out_port;
    logic [47:0] dest_mac;
    logic [7:0]  new_ttl;
    logic [15:0] new_checksum;
  } out_res_t;

  typedef struct packed {
    logic [31:0] prefix;
    logic [31:0] mask;
    logic [31:0] hop;
    logic [3:0]  port;
  } route_ent_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } nbr_ent_t;

  typedef struct packed {
    logic [COUNT_W-1:0] route_count;
    logic [COUNT_W-1:0] mac_count;
  } cfg_t;

  // one's complement add, end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

endpackage

/* design/ipv4fe_ram.sv */
module ipv4fe_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/ipv4fe_cfg.sv */
module ipv4fe_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ipv4fe_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output ipv4fe_pkg::cfg_t                    cfg
);

  typedef enum logic {
    REG_ROUTE_COUNT,
    REG_MAC_COUNT
  } reg_idx_t;

  ipv4fe_pkg::cfg_t cfg_r;
  ipv4fe_pkg::cfg_t cfg_nxt;
  reg_idx_t         idx;

  assign idx = reg_idx_t'(paddr[2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_ROUTE_COUNT: cfg_nxt.route_count = pwdata[ipv4fe_pkg::COUNT_W-1:0];
        REG_MAC_COUNT:   cfg_nxt.mac_count   = pwdata[ipv4fe_pkg::COUNT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_ROUTE_COUNT: prdata = {{(32-ipv4fe_pkg::COUNT_W){1'b0}}, cfg_r.route_count};
      REG_MAC_COUNT:   prdata = {{(32-ipv4fe_pkg::COUNT_W){1'b0}}, cfg_r.mac_count};
      default:         prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign cfg    = cfg_r;

endmodule

/* design/ipv4_forwarding_engine_top.sv */
// Channel   Ports                          Handshake
// request   start, busy, in_data           taken when start && !busy
// result    out_valid, out_data            one-cycle strobe, never held off
// config    psel/penable/pwrite/paddr/...  APB, pready tied high
//
// Loads and non-IPv4 frames: busy stays low, result strobed in the next cycle.
// Forward: checksum over nine header words (one word a cycle), then the route
// scan (one read a cycle, RAM reads registered), then the neighbour scan. The
// result is strobed in the cycle busy falls. Tables and datapath registers
// have no reset; config counts and control clear on synchronous reset.
// The receiver cannot stall.
module ipv4_forwarding_engine_top #(
  parameter int unsigned ROUTE_ENTRIES = ipv4fe_pkg::ROUTE_ENTRIES_DEF,
  parameter int unsigned MAC_ENTRIES   = ipv4fe_pkg::MAC_ENTRIES_DEF,
  parameter int unsigned PORT_COUNT    = ipv4fe_pkg::PORT_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  ipv4fe_pkg::in_req_t               in_data,
  output logic                              out_valid,
  output ipv4fe_pkg::out_res_t              out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ipv4fe_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int unsigned RAW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int unsigned MAW = (MAC_ENTRIES > 1) ? $clog2(MAC_ENTRIES) : 1;
  localparam int unsigned RCW = $clog2(ROUTE_ENTRIES + 1);
  localparam int unsigned MCW = $clog2(MAC_ENTRIES + 1);
  localparam int unsigned CW  = ipv4fe_pkg::CNT_CMP_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CSUM,
    S_ROUTE,
    S_MAC
  } state_t;

  ipv4fe_pkg::cfg_t cfg;

  state_t                state_r, state_nxt;
  logic [63:0]           hdr_first_r, hdr_first_nxt;
  logic [63:0]           hdr_middle_r, hdr_middle_nxt;
  logic [31:0]           hdr_dest_r, hdr_dest_nxt;
  logic [15:0]           csum_r, csum_nxt;
  logic [3:0]            wc_r, wc_nxt;
  logic [RCW-1:0]        ri_r, ri_nxt;
  logic                  rvld_r, rvld_nxt;
  logic [MCW-1:0]        mi_r, mi_nxt;
  logic                  mvld_r, mvld_nxt;
  logic [3:0]            port_r, port_nxt;
  logic [31:0]           hop_r, hop_nxt;
  logic [7:0]            nttl_r, nttl_nxt;
  logic [15:0]           nsum_r, nsum_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ipv4fe_pkg::out_res_t  out_r, out_nxt;

  logic                    accept;
  logic [RCW-1:0]          route_lim;
  logic [MCW-1:0]          mac_lim;
  logic                    r_we, r_re, m_we, m_re;
  logic [3:0]              port_clamped;
  ipv4fe_pkg::route_ent_t  r_wdata, r_rdata;
  ipv4fe_pkg::nbr_ent_t    m_wdata, m_rdata;
  logic                    route_hit, mac_hit;
  logic [15:0]             word, sum;
  logic [7:0]              ttl, proto;
  logic [15:0]             old_sum, new_sum;

  function automatic ipv4fe_pkg::out_res_t mk_res(input logic [2:0] v, input logic [3:0] p,
                                                  input logic [47:0] mac, input logic [7:0] t,
                                                  input logic [15:0] cs);
    ipv4fe_pkg::out_res_t r;
    r.verdict      = v;
    r.out_port     = p;
    r.dest_mac     = mac;
    r.new_ttl      = t;
    r.new_checksum = cs;
    return r;
  endfunction

  ipv4fe_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  assign route_lim = ({{(CW-ipv4fe_pkg::COUNT_W){1'b0}}, cfg.route_count} > CW'(ROUTE_ENTRIES))
                   ? RCW'(ROUTE_ENTRIES) : RCW'(cfg.route_count);
  assign mac_lim   = ({{(CW-ipv4fe_pkg::COUNT_W){1'b0}}, cfg.mac_count} > CW'(MAC_ENTRIES))
                   ? MCW'(MAC_ENTRIES) : MCW'(cfg.mac_count);

  assign port_clamped = ({5'b0, in_data.entry_port} >= ipv4fe_pkg::PORT_CMP_W'(PORT_COUNT))
                      ? 4'(PORT_COUNT - 1) : in_data.entry_port;

  assign r_we = accept && (in_data.opcode == ipv4fe_pkg::OP_ROUTE)
             && ({5'b0, in_data.entry_index} < CW'(ROUTE_ENTRIES));
  assign m_we = accept && (in_data.opcode == ipv4fe_pkg::OP_MAC)
             && ({5'b0, in_data.entry_index} < CW'(MAC_ENTRIES));

  always_comb begin
    r_wdata.prefix = in_data.entry_ip;
    r_wdata.mask   = in_data.entry_mask;
    r_wdata.hop    = in_data.entry_next_hop;
    r_wdata.port   = port_clamped;
    m_wdata.ip     = in_data.entry_ip;
    m_wdata.mac    = in_data.entry_mac;
  end

  assign r_re = (state_r == S_ROUTE) && (ri_r < route_lim);
  assign m_re = (state_r == S_MAC) && (mi_r < mac_lim);

  ipv4fe_ram #(
    .WIDTH ($bits(ipv4fe_pkg::route_ent_t)),
    .DEPTH (ROUTE_ENTRIES)
  ) u_route_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (RAW'(in_data.entry_index)),
    .wdata (r_wdata),
    .re    (r_re),
    .raddr (ri_r[RAW-1:0]),
    .rdata (r_rdata)
  );

  ipv4fe_ram #(
    .WIDTH ($bits(ipv4fe_pkg::nbr_ent_t)),
    .DEPTH (MAC_ENTRIES)
  ) u_nbr_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (MAW'(in_data.entry_index)),
    .wdata (m_wdata),
    .re    (m_re),
    .raddr (mi_r[MAW-1:0]),
    .rdata (m_rdata)
  );

  assign route_hit = rvld_r && ((r_rdata.mask & hdr_dest_r) == r_rdata.prefix);
  assign mac_hit   = mvld_r && (m_rdata.ip == hop_r);

  assign ttl     = hdr_middle_r[63:56];
  assign proto   = hdr_middle_r[55:48];
  assign old_sum = hdr_middle_r[47:32];
  // incremental update, RFC 1624
  assign new_sum = ~ipv4fe_pkg::oc_add(ipv4fe_pkg::oc_add(~old_sum, ~{ttl, proto}),
                                       {ttl - 8'd1, proto});

  always_comb begin
    case (wc_r)
      4'd0:    word = hdr_first_r[63:48];
      4'd1:    word = hdr_first_r[47:32];
      4'd2:    word = hdr_first_r[31:16];
      4'd3:    word = hdr_first_r[15:0];
      4'd4:    word = hdr_middle_r[63:48];
      4'd5:    word = hdr_middle_r[31:16];
      4'd6:    word = hdr_middle_r[15:0];
      4'd7:    word = hdr_dest_r[31:16];
      4'd8:    word = hdr_dest_r[15:0];
      default: word = '0;
    endcase
  end

  assign sum = ipv4fe_pkg::oc_add(csum_r, word);

  always_comb begin
    state_nxt      = state_r;
    hdr_first_nxt  = hdr_first_r;
    hdr_middle_nxt = hdr_middle_r;
    hdr_dest_nxt   = hdr_dest_r;
    csum_nxt       = csum_r;
    wc_nxt         = wc_r;
    ri_nxt         = ri_r;
    rvld_nxt       = rvld_r;
    mi_nxt         = mi_r;
    mvld_nxt       = mvld_r;
    port_nxt       = port_r;
    hop_nxt        = hop_r;
    nttl_nxt       = nttl_r;
    nsum_nxt       = nsum_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_data.opcode == ipv4fe_pkg::OP_FWD) begin
            if (in_data.frame_type != ipv4fe_pkg::ETHERTYPE_IPV4) begin
              out_valid_nxt = 1'b1;
              out_nxt = mk_res(ipv4fe_pkg::V_NOT_IPV4, '0, '0, '0, '0);
            end else begin
              hdr_first_nxt  = in_data.hdr_first;
              hdr_middle_nxt = in_data.hdr_middle;
              hdr_dest_nxt   = in_data.hdr_dest;
              csum_nxt       = '0;
              wc_nxt         = '0;
              state_nxt      = S_CSUM;
            end
          end else begin
            out_valid_nxt = 1'b1;
            out_nxt = mk_res(ipv4fe_pkg::V_LOAD_DONE, '0, '0, '0, '0);
          end
        end
      end
      S_CSUM: begin
        csum_nxt = sum;
        wc_nxt   = wc_r + 4'd1;
        if (wc_r == 4'(ipv4fe_pkg::CSUM_WORDS - 1)) begin
          if (~sum != old_sum) begin
            out_valid_nxt = 1'b1;
            out_nxt   = mk_res(ipv4fe_pkg::V_BAD_CSUM, '0, '0, '0, '0);
            state_nxt = S_IDLE;
          end else begin
            ri_nxt    = '0;
            rvld_nxt  = 1'b0;
            state_nxt = S_ROUTE;
          end
        end
      end
      S_ROUTE: begin
        ri_nxt   = r_re ? ri_r + RCW'(1) : ri_r;
        rvld_nxt = r_re;
        if (route_hit) begin
          if (ttl == 8'd0) begin
            out_valid_nxt = 1'b1;
            out_nxt   = mk_res(ipv4fe_pkg::V_TTL_ZERO, '0, '0, '0, '0);
            state_nxt = S_IDLE;
          end else begin
            port_nxt  = r_rdata.port;
            hop_nxt   = r_rdata.hop;
            nttl_nxt  = ttl - 8'd1;
            nsum_nxt  = new_sum;
            mi_nxt    = '0;
            mvld_nxt  = 1'b0;
            state_nxt = S_MAC;
          end
        end else if (!rvld_r && !r_re) begin
          out_valid_nxt = 1'b1;
          out_nxt   = mk_res(ipv4fe_pkg::V_NO_ROUTE, '0, '0, '0, '0);
          state_nxt = S_IDLE;
        end
      end
      S_MAC: begin
        mi_nxt   = m_re ? mi_r + MCW'(1) : mi_r;
        mvld_nxt = m_re;
        if (mac_hit) begin
          out_valid_nxt = 1'b1;
          out_nxt   = mk_res(ipv4fe_pkg::V_FORWARD, port_r, m_rdata.mac, nttl_r, nsum_r);
          state_nxt = S_IDLE;
        end else if (!mvld_r && !m_re) begin
          out_valid_nxt = 1'b1;
          out_nxt   = mk_res(ipv4fe_pkg::V_NO_MAC, port_r, '0, nttl_r, nsum_r);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rvld_r      <= 1'b0;
      mvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hdr_first_r  <= hdr_first_nxt;
      hdr_middle_r <= hdr_middle_nxt;
      hdr_dest_r   <= hdr_dest_nxt;
      csum_r       <= csum_nxt;
      wc_r         <= wc_nxt;
      ri_r         <= ri_nxt;
      rvld_r       <= rvld_nxt;
      mi_r         <= mi_nxt;
      mvld_r       <= mvld_nxt;
      port_r       <= port_nxt;
      hop_r        <= hop_nxt;
      nttl_r       <= nttl_nxt;
      nsum_r       <= nsum_nxt;
      out_valid_r  <= out_valid_nxt;
      out_r        <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_short_req_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ((in_data.opcode != ipv4fe_pkg::OP_FWD)
             || (in_data.frame_type != ipv4fe_pkg::ETHERTYPE_IPV4))) |=> out_valid)
    else $error("load or non-IPv4 request gave no result");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while still busy");

  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy without a request");

  a_drop_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.verdict != ipv4fe_pkg::V_FORWARD)
               && (out_data.verdict != ipv4fe_pkg::V_NO_MAC))
    |-> (out_data.out_port == '0 && out_data.dest_mac == '0
         && out_data.new_ttl == '0 && out_data.new_checksum == '0))
    else $error("dropped request carries field data");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUTE) |-> (ri_r <= route_lim))
    else $error("route scan ran past its limit");

endmodule
